// File: rtl/timed_task_queue_defines.svh
// Assertion macros used by the timed task queue checker.
`ifndef TIMED_TASK_QUEUE_DEFINES_SVH
`define TIMED_TASK_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TTQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ttq_pkg.sv
// Types, constants and codes for the timed task queue.
package ttq_pkg;

    localparam int DEPTH    = 32;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int TIME_W   = 24;
    localparam int HANDLE_W = 8;
    localparam int IVAL_W   = 16;
    localparam int STAT_W   = 2;
    localparam int QCNT_W   = 6;

    localparam logic KIND_REGISTER = 1'b0;
    localparam logic KIND_POLL     = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_DROPPED = 2'd2;

    typedef struct packed {
        logic                kind;
        logic [HANDLE_W-1:0] task_handle;
        logic [TIME_W-1:0]   due_time;
        logic [IVAL_W-1:0]   repeat_interval;
        logic [TIME_W-1:0]   now_time;
    } in_item_t;

    typedef struct packed {
        logic                fired;
        logic [HANDLE_W-1:0] fired_task;
        logic [STAT_W-1:0]   status;
        logic [QCNT_W-1:0]   queue_count;
    } out_item_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   due;
        logic [IVAL_W-1:0]   ival;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_REM_INSERT
    } cell_op_t;

    // broadcast to every cell
    typedef struct packed {
        cell_op_t op;
        entry_t   ent;
    } cell_ctrl_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   le;
        entry_t ent;
    } cell_link_t;

endpackage

// File: rtl/ttq_cell.sv
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
module ttq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head,
    input  ttq_pkg::cell_ctrl_t ctrl,
    input  ttq_pkg::cell_link_t left,
    input  ttq_pkg::cell_link_t right,
    output ttq_pkg::cell_link_t link
);

    logic            valid_reg;
    logic            valid_next;
    ttq_pkg::entry_t ent_reg;
    ttq_pkg::entry_t ent_next;
    logic            le;

    // entry sorts at or before the new key
    assign le = valid_reg && (ent_reg.due <= ctrl.ent.due);

    always_comb
    begin
        valid_next = valid_reg;
        ent_next   = ent_reg;
        unique case (ctrl.op)
            ttq_pkg::OP_HOLD:
            begin
                valid_next = valid_reg;
            end
            ttq_pkg::OP_INSERT:
            begin
                if (!le)
                begin
                    if (left.le)
                    begin
                        valid_next = 1'b1;
                        ent_next   = ctrl.ent;
                    end
                    else
                    begin
                        valid_next = left.valid;
                        ent_next   = left.ent;
                    end
                end
            end
            ttq_pkg::OP_REMOVE:
            begin
                valid_next = right.valid;
                ent_next   = right.ent;
            end
            ttq_pkg::OP_REM_INSERT:
            begin
                // remove head, then insert into the shifted view
                if (right.le)
                begin
                    valid_next = right.valid;
                    ent_next   = right.ent;
                end
                else if (head || le)
                begin
                    valid_next = 1'b1;
                    ent_next   = ctrl.ent;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign link.valid = valid_reg;
    assign link.le    = le;
    assign link.ent   = ent_reg;

endmodule

// File: rtl/timed_task_queue.sv
// Top level of the timed task queue: cell chain, control and result buffer.
//
//   channel | signals                       | payload
//   input   | in_valid / in_ready           | in_data  (ttq_pkg::in_item_t)
//   output  | out_valid / out_ready         | out_data (ttq_pkg::out_item_t)
//
// One item per cycle while in_ready is high: every cell compares its due time
// against the new key in parallel and shifts, inserts or holds in the same
// cycle as the accept. The result is registered in the two-entry result
// buffer (out_reg, skid_reg), which lets one more item in while out_ready is
// low. Reset empties the queue; entry payloads are not cleared.
module timed_task_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ttq_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ttq_pkg::out_item_t out_data
);

    ttq_pkg::cell_link_t links [ttq_pkg::DEPTH];
    ttq_pkg::cell_ctrl_t ctrl;

    logic [ttq_pkg::CNT_W-1:0] count_reg;
    logic [ttq_pkg::CNT_W-1:0] count_next;

    ttq_pkg::out_item_t out_reg;
    ttq_pkg::out_item_t out_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    ttq_pkg::out_item_t skid_reg;
    ttq_pkg::out_item_t skid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;

    ttq_pkg::out_item_t result;
    ttq_pkg::entry_t    head_ent;
    logic               accept;
    logic               pop;
    logic               full;
    logic               fire;
    logic               rearm;

    genvar gi;
    generate
        for (gi = 0; gi < ttq_pkg::DEPTH; gi++)
        begin : g_cell
            ttq_pkg::cell_link_t left_l;
            ttq_pkg::cell_link_t right_l;
            if (gi == 0)
            begin : g_first
                // boundary: new entry may always land in front
                assign left_l.valid = 1'b0;
                assign left_l.le    = 1'b1;
                assign left_l.ent   = '0;
            end
            else
            begin : g_mid_l
                assign left_l = links[gi-1];
            end
            if (gi == ttq_pkg::DEPTH - 1)
            begin : g_last
                assign right_l.valid = 1'b0;
                assign right_l.le    = 1'b0;
                assign right_l.ent   = '0;
            end
            else
            begin : g_mid_r
                assign right_l = links[gi+1];
            end
            ttq_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .head  ((gi == 0) ? 1'b1 : 1'b0),
                .ctrl  (ctrl),
                .left  (left_l),
                .right (right_l),
                .link  (links[gi])
            );
        end
    endgenerate

    assign head_ent = links[0].ent;
    assign accept   = in_valid && in_ready;
    assign in_ready = !skid_valid_reg;
    assign pop      = out_valid_reg && out_ready;
    assign full     = (count_reg == ttq_pkg::CNT_W'(ttq_pkg::DEPTH));
    assign fire     = (in_data.kind == ttq_pkg::KIND_POLL) && links[0].valid
                      && (head_ent.due <= in_data.now_time);
    assign rearm    = (head_ent.ival != '0);

    always_comb
    begin
        ctrl.op      = ttq_pkg::OP_HOLD;
        ctrl.ent     = '0;
        count_next   = count_reg;
        result       = '0;
        result.status = ttq_pkg::ST_OK;
        if (in_data.kind == ttq_pkg::KIND_REGISTER)
        begin
            ctrl.ent.handle = in_data.task_handle;
            ctrl.ent.due    = in_data.due_time;
            ctrl.ent.ival   = in_data.repeat_interval;
            if (full)
            begin
                result.status = ttq_pkg::ST_FULL;
            end
            else
            begin
                ctrl.op    = ttq_pkg::OP_INSERT;
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            ctrl.ent.handle = head_ent.handle;
            ctrl.ent.due    = in_data.now_time + ttq_pkg::TIME_W'(head_ent.ival);
            ctrl.ent.ival   = head_ent.ival;
            if (fire)
            begin
                result.fired      = 1'b1;
                result.fired_task = head_ent.handle;
                if (rearm && !full)
                begin
                    ctrl.op = ttq_pkg::OP_REM_INSERT;
                end
                else
                begin
                    ctrl.op    = ttq_pkg::OP_REMOVE;
                    count_next = count_reg - 1'b1;
                    if (rearm)
                    begin
                        result.status = ttq_pkg::ST_DROPPED;
                    end
                end
            end
        end
        result.queue_count = ttq_pkg::QCNT_W'(count_next);
        if (!accept)
        begin
            ctrl.op    = ttq_pkg::OP_HOLD;
            count_next = count_reg;
        end
    end

    // two-entry result buffer
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (accept)
        begin
            if (!out_valid_next)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: rtl/ttq_checker.sv
// Port-level checker for the timed task queue, bound to the top level.
`include "timed_task_queue_defines.svh"

module ttq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input ttq_pkg::out_item_t out_data
);

    `TTQ_ASSERT_NOW(a_idle_handle, out_valid && !out_data.fired,
                    out_data.fired_task == '0, "fired_task set without a fire")
    `TTQ_ASSERT_NOW(a_full_no_fire, out_valid && out_data.status == ttq_pkg::ST_FULL,
                    !out_data.fired, "register reject reported a fire")
    `TTQ_ASSERT_NOW(a_drop_fired, out_valid && out_data.status == ttq_pkg::ST_DROPPED,
                    out_data.fired, "dropped reinsert without a fire")
    `TTQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                     out_valid && $stable(out_data), "result changed while stalled")
    `TTQ_ASSERT_NEXT(a_accept_result, in_valid && in_ready,
                     out_valid, "no result after an input transfer")

endmodule

bind timed_task_queue ttq_checker u_ttq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
